// ===== design/edu_pkg.sv =====
// Shared types and constants for the Euclidean distance unit.
// Used by the front end, the sum queue, the square root engine and the top level.
`default_nettype none

package edu_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DIM_MAX     = 1024;
  localparam int LEN_WIDTH   = 11;
  localparam logic [LEN_WIDTH-1:0] LEN_RESET = 11'd960;
  localparam int CNT_WIDTH   = $clog2(DIM_MAX);
  localparam int SQ_WIDTH    = 2 * COORD_WIDTH;
  localparam int SUM_WIDTH   = 42;
  localparam int DIST_WIDTH  = SUM_WIDTH / 2;
  localparam int REM_WIDTH   = DIST_WIDTH + 3;
  localparam int STEP_WIDTH  = $clog2(DIST_WIDTH);

  localparam int QDEPTH      = 2;
  localparam int QPTR_WIDTH  = $clog2(QDEPTH);
  localparam int QCNT_WIDTH  = $clog2(QDEPTH + 1);

  localparam int IN_TDATA_WIDTH  = 2 * COORD_WIDTH;
  localparam int OUT_TDATA_WIDTH = ((DIST_WIDTH + 7) / 8) * 8;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_RUN,
    SQ_FINISH
  } sqrt_state_e;

  typedef struct packed {
    logic [QCNT_WIDTH-1:0] count;
    logic                  full;
    logic                  empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

// ===== design/edu_fifo.sv =====
// Two-entry queue of finished sums between the front end and the square root engine.
// Depends on edu_pkg.
`default_nettype none

module edu_fifo import edu_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire logic [SUM_WIDTH-1:0] push_data_i,
  input  wire logic                 pop_i,
  output logic      [SUM_WIDTH-1:0] pop_data_o,
  output fifo_stat_t                stat_o
);

  logic [SUM_WIDTH-1:0]  mem_q [QDEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_WIDTH-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_WIDTH'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_WIDTH'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign pop_data_o   = mem_q[rd_ptr_q];
  assign stat_o.count = count_q;
  assign stat_o.full  = (count_q == QCNT_WIDTH'(QDEPTH));
  assign stat_o.empty = (count_q == '0);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_WIDTH'(QDEPTH))
    else $error("queue count above depth");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ===== design/edu_front.sv =====
// Front end: takes coordinate pairs, squares the difference over two stages,
// accumulates the sum and pushes it into the queue on the last pair. Depends on edu_pkg.
`default_nettype none

module edu_front import edu_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [LEN_WIDTH-1:0]   cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [COORD_WIDTH-1:0] coord_a_i,
  input  wire logic [COORD_WIDTH-1:0] coord_b_i,
  input  wire fifo_stat_t             stat_i,
  output logic                        push_o,
  output logic      [SUM_WIDTH-1:0]   push_data_o
);

  logic [LEN_WIDTH-1:0]   len_q;
  logic [LEN_WIDTH-1:0]   len_eff;
  logic [CNT_WIDTH-1:0]   cnt_q;
  logic [LEN_WIDTH-1:0]   cnt_plus;
  logic                   is_last;
  logic                   accept;

  logic signed [COORD_WIDTH:0] diff;
  logic [COORD_WIDTH:0]   diff_abs;

  logic                   a_valid_q, a_last_q;
  logic [COORD_WIDTH-1:0] mag_q;
  logic                   b_valid_q, b_last_q;
  logic [SQ_WIDTH-1:0]    sq_q;
  logic [SUM_WIDTH-1:0]   sum_q;
  logic [SUM_WIDTH:0]     sum_ext;
  logic [SUM_WIDTH-1:0]   sum_sat;
  logic [QCNT_WIDTH:0]    pending;

  // clamp the length into 1..DIM_MAX
  always_comb begin
    if (len_q == '0) begin
      len_eff = LEN_WIDTH'(1);
    end else if (len_q > LEN_WIDTH'(DIM_MAX)) begin
      len_eff = LEN_WIDTH'(DIM_MAX);
    end else begin
      len_eff = len_q;
    end
  end

  assign cnt_plus = LEN_WIDTH'(cnt_q) + LEN_WIDTH'(1);
  assign is_last  = (cnt_plus >= len_eff);

  // hold off input while the queue could not take every sum already in flight
  assign pending    = (QCNT_WIDTH + 1)'(stat_i.count) + (QCNT_WIDTH + 1)'(a_valid_q & a_last_q)
                    + (QCNT_WIDTH + 1)'(b_valid_q & b_last_q);
  assign in_ready_o = (pending < (QCNT_WIDTH + 1)'(QDEPTH));
  assign accept     = in_valid_i && in_ready_o;

  assign diff     = $signed({coord_a_i[COORD_WIDTH-1], coord_a_i})
                  - $signed({coord_b_i[COORD_WIDTH-1], coord_b_i});
  assign diff_abs = diff[COORD_WIDTH] ? (COORD_WIDTH + 1)'(-diff) : diff;

  assign sum_ext     = {1'b0, sum_q} + (SUM_WIDTH + 1)'(sq_q);
  assign sum_sat     = sum_ext[SUM_WIDTH] ? '1 : sum_ext[SUM_WIDTH-1:0];
  assign push_o      = b_valid_q && b_last_q;
  assign push_data_o = sum_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= LEN_RESET;
      cnt_q     <= '0;
      a_valid_q <= 1'b0;
      a_last_q  <= 1'b0;
      b_valid_q <= 1'b0;
      b_last_q  <= 1'b0;
      sum_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      if (accept) begin
        cnt_q <= is_last ? '0 : cnt_plus[CNT_WIDTH-1:0];
      end
      a_valid_q <= accept;
      a_last_q  <= accept && is_last;
      b_valid_q <= a_valid_q;
      b_last_q  <= a_last_q;
      if (b_valid_q) begin
        sum_q <= b_last_q ? '0 : sum_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mag_q <= diff_abs[COORD_WIDTH-1:0];
    end
    if (a_valid_q) begin
      sq_q <= SQ_WIDTH'(mag_q) * SQ_WIDTH'(mag_q);
    end
  end

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !stat_i.full)
    else $error("sum pushed into a full queue");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_last) |=> cnt_q == '0)
    else $error("pair count not cleared after last pair");
`endif

endmodule

`default_nettype wire

// ===== design/edu_isqrt.sv =====
// Back end: bit-pair restoring square root, one result bit per cycle, with an
// output register toward the result channel. Depends on edu_pkg.
`default_nettype none

module edu_isqrt import edu_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire fifo_stat_t            stat_i,
  input  wire logic [SUM_WIDTH-1:0]  pop_data_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic      [DIST_WIDTH-1:0] out_data_o
);

  sqrt_state_e state_q, state_d;

  logic [SUM_WIDTH-1:0]  rad_q;
  logic [REM_WIDTH-1:0]  rem_q;
  logic [DIST_WIDTH-1:0] root_q;
  logic [STEP_WIDTH-1:0] step_q;
  logic                  out_valid_q;
  logic [DIST_WIDTH-1:0] out_data_q;

  logic [REM_WIDTH-1:0]  rem_shift, trial, rem_next;
  logic                  ge;
  logic                  load_out;

  assign rem_shift = {rem_q[REM_WIDTH-3:0], rad_q[SUM_WIDTH-1 -: 2]};
  assign trial     = {1'b0, root_q, 2'b01};
  assign ge        = (rem_shift >= trial);
  assign rem_next  = ge ? rem_shift - trial : rem_shift;

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      SQ_IDLE: begin
        if (!stat_i.empty) begin
          pop_o   = 1'b1;
          state_d = SQ_RUN;
        end
      end
      SQ_RUN: begin
        if (step_q == '0) begin
          state_d = SQ_FINISH;
        end
      end
      SQ_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = SQ_IDLE;
        end
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        step_q <= STEP_WIDTH'(DIST_WIDTH - 1);
      end else if (state_q == SQ_RUN) begin
        step_q <= step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rad_q  <= pop_data_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (state_q == SQ_RUN) begin
      rad_q  <= rad_q << 2;
      rem_q  <= rem_next;
      root_q <= {root_q[DIST_WIDTH-2:0], ge};
    end
    if (load_out) begin
      out_data_q <= root_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");
`endif

endmodule

`default_nettype wire

// ===== design/euclidean_distance_unit.sv =====
// Euclidean distance unit, top level: front end, sum queue and square root engine.
// Depends on edu_pkg, edu_front, edu_fifo and edu_isqrt.
//
// Usage:
//   s_axis carries one coordinate pair per word: coord_a and coord_b, signed Q8.8.
//   m_axis carries one distance word per vector: floor(sqrt(sum of squared
//   differences)), unsigned Q13.8.
//   cfg_we_i / cfg_wdata_i set vector_length (pairs per vector; 0 acts as 1,
//   values above 1024 act as 1024). Write it only while the block is idle.
// Throughput: one pair per cycle while the sum queue has room. A sum in flight
//   needs a queue slot; the square root engine pops a sum only once it is done
//   with the last root, so short vectors make the input wait on the engine.
// Path: a sum goes through the magnitude and square registers into the queue;
//   the idle engine pops it, builds the root one bit a cycle and, once the
//   output register is free, loads it there to raise m_axis_tvalid.
// Reset: clears the running sum, the pair count and the queue, and sets
//   vector_length to 960.
// Stall: the result waits in the output register; the engine finishes the next
//   root and holds it, the queue fills, then s_axis_tready drops.
`default_nettype none

module euclidean_distance_unit import edu_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [LEN_WIDTH-1:0]       cfg_wdata_i,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // [15:0] coord_a, [31:16] coord_b
  input  wire logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // [20:0] distance, [23:21] zero
  output logic      [OUT_TDATA_WIDTH-1:0] m_axis_tdata
);

  fifo_stat_t            stat;
  logic                  push, pop;
  logic [SUM_WIDTH-1:0]  push_data, pop_data;
  logic [DIST_WIDTH-1:0] root_word;

  edu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .coord_a_i   (s_axis_tdata[COORD_WIDTH-1:0]),
    .coord_b_i   (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .stat_i      (stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  edu_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (stat)
  );

  edu_isqrt u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (stat),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (root_word)
  );

  assign m_axis_tdata = OUT_TDATA_WIDTH'(root_word);

endmodule

`default_nettype wire

// ===== tb/euclidean_distance_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for euclidean_distance_unit: streams coordinate pairs,
// predicts each distance in a scoreboard class and checks every output word.
// Depends on edu_pkg and the euclidean_distance_unit RTL.

module euclidean_distance_unit_tb;
  import edu_pkg::*;

  localparam int RANDOM_PAIRS = 1830;
  localparam int DRAIN_CYCLES = 40;

  class l2_scoreboard;
    logic [LEN_WIDTH-1:0]  vec_len;
    longint unsigned       sum_sq;
    int unsigned           pairs_in_vec;
    logic [DIST_WIDTH-1:0] pending_distances[$];
    int unsigned           mismatches;
    int unsigned           distances_seen;
    int unsigned           pairs_seen;

    function new();
      vec_len        = LEN_RESET;
      sum_sq         = 0;
      pairs_in_vec   = 0;
      mismatches     = 0;
      distances_seen = 0;
      pairs_seen     = 0;
    endfunction

    function void set_length(logic [LEN_WIDTH-1:0] len);
      vec_len = len;
    endfunction

    // Build the root one bit at a time from the top.
    function longint unsigned floor_root(longint unsigned n);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int i = DIST_WIDTH - 1; i >= 0; i--) begin
        trial = root | (64'd1 << i);
        if (trial * trial <= n) root = trial;
      end
      return root;
    endfunction

    function void add_pair(logic [COORD_WIDTH-1:0] a, logic [COORD_WIDTH-1:0] b);
      longint          diff;
      longint unsigned sq;
      longint unsigned sum_max;
      int unsigned     eff_len;
      sum_max = (64'd1 << SUM_WIDTH) - 1;
      diff = longint'($signed(a)) - longint'($signed(b));
      sq = (diff < 0) ? -diff : diff;
      sq = sq * sq;
      eff_len = (vec_len == 0) ? 1 : ((vec_len > DIM_MAX) ? DIM_MAX : vec_len);
      sum_sq = (sq > sum_max - sum_sq) ? sum_max : sum_sq + sq;
      pairs_seen++;
      pairs_in_vec++;
      if (pairs_in_vec >= eff_len) begin
        pending_distances.insert(pending_distances.size(), DIST_WIDTH'(floor_root(sum_sq)));
        sum_sq       = 0;
        pairs_in_vec = 0;
      end
    endfunction

    function void take_distance(logic [OUT_TDATA_WIDTH-1:0] word);
      logic [OUT_TDATA_WIDTH-1:0] want;
      distances_seen++;
      if (pending_distances.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: unexpected distance word %0d", $realtime, word);
        return;
      end
      want = OUT_TDATA_WIDTH'(pending_distances.pop_front());
      if (word !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: distance mismatch: expected %0d, got %0d", $realtime, want, word);
      end
    endfunction
  endclass

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       cfg_we_i      = 1'b0;
  logic [LEN_WIDTH-1:0]       cfg_wdata_i   = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  // [15:0] coord_a, [31:16] coord_b
  logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata  = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  // [20:0] distance, [23:21] zero
  logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned len_writes    = 0;
  l2_scoreboard sb = new();

  euclidean_distance_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.add_pair(s_axis_tdata[COORD_WIDTH-1:0], s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.take_distance(m_axis_tdata);
  end

  // Call at a rising edge; returns at the edge where the word was taken, valid still high.
  task automatic send_pair(input logic [COORD_WIDTH-1:0] a, input logic [COORD_WIDTH-1:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid, drain every pending distance, then let the pipeline go quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_distances.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [LEN_WIDTH-1:0] len);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    sb.set_length(len);
    len_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [COORD_WIDTH-1:0] pick_coord();
    case ($urandom_range(15))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return COORD_WIDTH'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned random_sent;
    int unsigned phase_no;
    int unsigned len;
    int unsigned n_vec;
    int unsigned mode;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset length is 960: a partial vector, then lower the length below the count.
    send_pair(16'h7FFF, 16'h8000);
    send_pair(16'h8000, 16'h7FFF);
    send_pair(16'h1234, 16'hFFFF);
    settle();
    write_length(2);
    send_pair(16'h0000, 16'h0000);
    settle();

    // Zero length acts as one: a distance per word.
    write_length(0);
    send_pair(16'h7FFF, 16'h8000);
    send_pair(16'h8000, 16'h7FFF);
    send_pair(16'h0000, 16'h0000);
    send_pair(16'hFFFF, 16'h0001);
    send_pair(16'h8000, 16'h8000);
    send_pair(16'h7FFF, 16'h7FFF);
    settle();
    write_length(1);
    send_pair(16'h0100, 16'h0000);
    send_pair(16'h5555, 16'hAAAA);
    send_pair(16'hAAAA, 16'h5555);
    settle();

    // Top of the register clamps to the maximum; then cut the vector short.
    write_length(11'h7FF);
    send_pair(16'h7FFF, 16'h8000);
    send_pair(16'h8000, 16'h7FFF);
    send_pair(16'h7FFF, 16'h8000);
    settle();
    write_length(1);
    send_pair(16'h8000, 16'h7FFF);
    settle();
    write_length(3);
    send_pair(16'h0001, 16'hFFFF);
    send_pair(16'hFF00, 16'h0100);
    send_pair(16'h4000, 16'hC000);
    settle();

    random_sent = 0;
    phase_no    = 0;
    while (random_sent < RANDOM_PAIRS) begin
      mode = random_sent * 3 / RANDOM_PAIRS;
      send_idle_pct = (mode == 0) ? 35 : ((mode == 1) ? 50 : 0);
      recv_idle_pct = (mode == 0) ? 50 : ((mode == 1) ? 35 : 0);
      if (phase_no == 2) begin
        len = DIM_MAX;
      end else begin
        case ($urandom_range(9))
          0:          len = 0;
          1:          len = 1;
          2:          len = 2;
          7:          len = $urandom_range(41, 120);
          default:    len = $urandom_range(3, 40);
        endcase
      end
      n_vec = $urandom_range(60, 150) / ((len == 0) ? 1 : len);
      if (n_vec == 0) n_vec = 1;
      write_length(LEN_WIDTH'(len));
      for (int v = 0; v < n_vec; v++) begin
        for (int p = 0; p < ((len == 0) ? 1 : len); p++) begin
          send_pair(pick_coord(), pick_coord());
          random_sent++;
        end
      end
      settle();
      phase_no++;
    end

    if (sb.pending_distances.size() != 0) begin
      sb.mismatches += sb.pending_distances.size();
      $display("%0d distances never arrived", sb.pending_distances.size());
    end
    $display("Streamed %0d coordinate pairs, checked %0d distances, %0d length writes.",
             sb.pairs_seen, sb.distances_seen, len_writes);
    $display("Lengths from 0 to above the maximum, with and without idling on both sides.");
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4_800_000;
    $display("Timeout: run did not finish");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
design/edu_pkg.sv
design/edu_fifo.sv
design/edu_front.sv
design/edu_isqrt.sv
design/euclidean_distance_unit.sv
tb/euclidean_distance_unit_tb.sv
